>>> hdl/sstb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the size string parser.
// No dependencies; imported by every module of the block.
package sstb_pkg;

   localparam int VALUE_BITS_DEFAULT = 64;
   localparam int BYTE_COUNT_BITS    = 64;
   localparam int WORD_BYTES_BITS    = 5;
   localparam int CSR_ADDR_BITS      = 2;
   localparam int CSR_DATA_BITS      = 32;
   localparam int KIBI_SHIFT         = 10;   // 1024 = 2**10

   localparam logic [WORD_BYTES_BITS-1:0] WORD_BYTES_RESET = 5'd8;
   localparam logic [CSR_ADDR_BITS-1:0]   CSR_ADDR_WORD_BYTES = 2'd0;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_K     = 8'h6B;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [4:0] DIGIT_NONE = 5'd31;
   localparam logic [4:0] OCT_LIMIT  = 5'd8;
   localparam logic [4:0] DEC_LIMIT  = 5'd10;
   localparam logic [4:0] HEX_LIMIT  = 5'd16;

   typedef enum logic [6:0] {
      PH_WS    = 7'b0000001,
      PH_SIGN  = 7'b0000010,
      PH_ZERO  = 7'b0000100,
      PH_XPRE  = 7'b0001000,
      PH_DIG   = 7'b0010000,
      PH_UNIT2 = 7'b0100000,
      PH_DONE  = 7'b1000000
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_OCT = 2'd1,
      RX_HEX = 2'd2
   } radix_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_COUNT_BITS-1:0] byte_count;
      logic                       parse_error;
   } rsp_payload_type;

   typedef struct packed {
      logic            fire;
      req_payload_type item;
   } step_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] d;
      d = DIGIT_NONE;
      if (c >= CH_0 && c <= CH_9) d = 5'(c - CH_0);
      else if (c >= CH_LO_A && c <= CH_LO_F) d = 5'(c - CH_LO_A) + 5'd10;
      else if (c >= CH_UP_A && c <= CH_UP_F) d = 5'(c - CH_UP_A) + 5'd10;
      return d;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFFSET : c;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic [4:0] radix_limit(input radix_type rx);
      logic [4:0] lim;
      case (rx)
         RX_OCT:  lim = OCT_LIMIT;
         RX_HEX:  lim = HEX_LIMIT;
         default: lim = DEC_LIMIT;
      endcase
      return lim;
   endfunction

endpackage

>>> hdl/sstb_csr.sv
`timescale 1ns / 1ps
// Register file of the size string parser: the word size for the w unit.
// Depends on sstb_pkg.
module sstb_csr
   import sstb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_BITS-1:0]   paddr,
   input  logic [CSR_DATA_BITS-1:0]   pwdata,
   output logic [CSR_DATA_BITS-1:0]   prdata,
   output logic                       pready,
   output logic [WORD_BYTES_BITS-1:0] word_bytes
);

   logic [WORD_BYTES_BITS-1:0] word_bytes_ff;
   logic [WORD_BYTES_BITS-1:0] word_bytes_in;
   logic                       wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && pready && (paddr == CSR_ADDR_WORD_BYTES);

   always_comb begin
      word_bytes_in = word_bytes_ff;
      if (wr_hit) word_bytes_in = pwdata[WORD_BYTES_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_bytes_ff <= WORD_BYTES_RESET;
      end else begin
         word_bytes_ff <= word_bytes_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr)
         CSR_ADDR_WORD_BYTES: prdata = CSR_DATA_BITS'(word_bytes_ff);
         default:             prdata = '0;
      endcase
   end

   assign word_bytes = word_bytes_ff;

endmodule

>>> hdl/sstb_core.sv
`timescale 1ns / 1ps
// Parse state machine: number accumulation, sign, radix, units and the final result.
// Depends on sstb_pkg.
module sstb_core
   import sstb_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  step_type                   step,
   input  logic [WORD_BYTES_BITS-1:0] word_bytes,
   output result_type                 result
);

   localparam int WIDE_BITS = VALUE_BITS + 4;

   phase_type             phase_ff, phase_in;
   radix_type             radix_ff, radix_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic                  ovf_ff, ovf_in;
   logic                  err_ff, err_in;

   logic [WIDE_BITS-1:0]  acc_ext;
   logic [WIDE_BITS-1:0]  acc_wide;
   logic [VALUE_BITS-1:0] acc_settled;
   logic [VALUE_BITS-1:0] acc_word;

   assign acc_ext = WIDE_BITS'(acc_ff);

   always_comb begin
      case (radix_ff)
         RX_OCT:  acc_wide = acc_ext << 3;
         RX_HEX:  acc_wide = acc_ext << 4;
         default: acc_wide = (acc_ext << 3) + (acc_ext << 1);
      endcase
      acc_wide = acc_wide + WIDE_BITS'(digit_value(step.item.character));
   end

   assign acc_settled = ovf_ff ? {VALUE_BITS{1'b1}} :
                        neg_ff ? (~acc_ff) + VALUE_BITS'(1) : acc_ff;
   assign acc_word    = VALUE_BITS'(acc_ff * VALUE_BITS'(word_bytes));

   always_comb begin
      logic [7:0] c;
      logic [7:0] l;
      logic [4:0] d;
      logic       start;
      logic       accum;
      logic       unit;
      c      = step.item.character;
      l      = to_lower(c);
      d      = digit_value(c);
      start  = 1'b0;
      accum  = 1'b0;
      unit   = 1'b0;
      phase_in = phase_ff;
      radix_in = radix_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      err_in   = err_ff;
      result   = '0;
      if (step.fire) begin
         unique case (phase_ff)
            PH_WS: begin
               if (!is_space(c)) begin
                  if (c == CH_PLUS || c == CH_MINUS) begin
                     neg_in   = (c == CH_MINUS);
                     phase_in = PH_SIGN;
                  end else begin
                     start = 1'b1;
                  end
               end
            end
            PH_SIGN: start = 1'b1;
            PH_ZERO: begin
               if (c == CH_X_UP || c == CH_X_LO) begin
                  phase_in = PH_XPRE;
               end else if (d < OCT_LIMIT) begin
                  accum    = 1'b1;
                  phase_in = PH_DIG;
               end else begin
                  unit = 1'b1;
               end
            end
            PH_XPRE: begin
               if (d < HEX_LIMIT) begin
                  radix_in = RX_HEX;
                  acc_in   = VALUE_BITS'(d);
                  phase_in = PH_DIG;
               end else begin
                  err_in   = 1'b1;
                  phase_in = PH_DONE;
               end
            end
            PH_DIG: begin
               if (d < radix_limit(radix_ff)) accum = 1'b1;
               else unit = 1'b1;
            end
            PH_UNIT2: begin
               if (l == CH_W) acc_in = acc_word;
               else if (l != CH_B && c != CH_NUL) err_in = 1'b1;
               phase_in = PH_DONE;
            end
            default: ;
         endcase

         if (start) begin
            acc_in = '0;
            if (c == CH_0) begin
               radix_in = RX_OCT;
               phase_in = PH_ZERO;
            end else if (c >= CH_1 && c <= CH_9) begin
               radix_in = RX_DEC;
               acc_in   = VALUE_BITS'(c - CH_0);
               phase_in = PH_DIG;
            end else begin
               neg_in   = 1'b0;
               phase_in = PH_DONE;
            end
         end

         if (accum && !ovf_ff) begin
            if (acc_wide[WIDE_BITS-1:VALUE_BITS] != '0) ovf_in = 1'b1;
            else acc_in = acc_wide[VALUE_BITS-1:0];
         end

         if (unit) begin
            neg_in   = 1'b0;
            ovf_in   = 1'b0;
            phase_in = PH_UNIT2;
            case (l)
               CH_K:    acc_in = acc_settled << KIBI_SHIFT;
               CH_M:    acc_in = acc_settled << (2 * KIBI_SHIFT);
               CH_G:    acc_in = acc_settled << (3 * KIBI_SHIFT);
               CH_T:    acc_in = acc_settled << (4 * KIBI_SHIFT);
               default: begin
                  acc_in   = acc_settled;
                  phase_in = PH_DONE;
                  if (l != CH_B && c != CH_NUL) err_in = 1'b1;
               end
            endcase
         end

         if (step.item.last_char) begin
            if (phase_in == PH_ZERO || phase_in == PH_DIG) begin
               acc_in = ovf_in ? {VALUE_BITS{1'b1}} :
                        neg_in ? (~acc_in) + VALUE_BITS'(1) : acc_in;
            end else if (phase_in == PH_XPRE) begin
               err_in = 1'b1;
            end else if (phase_in == PH_WS || phase_in == PH_SIGN) begin
               acc_in = '0;
            end
            result.valid               = 1'b1;
            result.payload.byte_count  = err_in ? '0 : BYTE_COUNT_BITS'(acc_in);
            result.payload.parse_error = err_in;
            phase_in = PH_WS;
            radix_in = RX_DEC;
            acc_in   = '0;
            neg_in   = 1'b0;
            ovf_in   = 1'b0;
            err_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WS;
         radix_ff <= RX_DEC;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         ovf_ff   <= ovf_in;
         err_ff   <= err_in;
      end
   end

   // a finished string leaves the parser clean for the next one
   a_clean_after_last: assert property (@(posedge clock) disable iff (reset)
      step.fire && step.item.last_char |=>
         phase_ff == PH_WS && acc_ff == '0 && !err_ff && !neg_ff && !ovf_ff)
      else $error("parser state not cleared after last character");

   // overflow only ever raised while digits are being read
   a_ovf_in_digits: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> phase_ff == PH_DIG)
      else $error("overflow flag set outside digit phase");

endmodule

>>> hdl/size_string_to_bytes_parser.sv
`timescale 1ns / 1ps
// Size string parser: one character per transfer in, one byte count per string out.
// One character is taken every cycle unless the input stalls. A character is parsed in a single pass while it
// sits in the input register; the last character's result is registered in the output register
// from that pass. The rate is set by the parse state update, one shift-add accumulate or
// unit scaling per cycle.
// The input stalls only while a last character waits for a stalled output register.
// Depends on sstb_pkg, sstb_csr and sstb_core.
module size_string_to_bytes_parser
   import sstb_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_payload_type          req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_payload_type          rsp_payload,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic                       s1_valid_ff, s1_valid_in;
   req_payload_type            s1_item_ff, s1_item_in;
   logic                       out_valid_ff, out_valid_in;
   rsp_payload_type            out_payload_ff, out_payload_in;
   logic                       proc_fire;
   logic                       req_xfer;
   logic [WORD_BYTES_BITS-1:0] word_bytes;
   step_type                   step;
   result_type                 result;

   sstb_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .word_bytes (word_bytes)
   );

   assign proc_fire = s1_valid_ff && !(s1_item_ff.last_char && out_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !proc_fire;
   assign req_xfer  = req_valid && !req_stall;

   assign step.fire = proc_fire;
   assign step.item = s1_item_ff;

   sstb_core #(
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .word_bytes (word_bytes),
      .result     (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_payload;
      end else if (proc_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_payload_in = out_payload_ff;
      if (result.valid) begin
         out_valid_in   = 1'b1;
         out_payload_in = result.payload;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_item_ff     <= s1_item_in;
      out_payload_ff <= out_payload_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_item_ff.last_char && out_valid_ff)
      else $error("input stalled without a blocked last character");

   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_item_ff.last_char && out_valid_ff && rsp_stall |=>
         s1_valid_ff && $stable(s1_item_ff))
      else $error("last character dropped while output was blocked");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      result.valid |=> rsp_valid && rsp_payload == $past(result.payload))
      else $error("parsed result not loaded into output register");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.parse_error |-> rsp_payload.byte_count == '0)
      else $error("byte count not zero on parse error");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.byte_count >> VALUE_BITS) == '0)
      else $error("byte count exceeds value width");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for size_string_to_bytes_parser: streams size strings one character per transfer
// and checks every byte count against a parser model kept in the bench.
// Depends on sstb_pkg and the parser RTL; needs no files or arguments.
module tb_top;
   import sstb_pkg::*;

   localparam int CLOCK_HALF       = 6;
   localparam int RESET_CYCLES     = 11;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES    = 4;
   localparam int RANDOM_ITEMS     = 910;
   localparam int NOT_A_DIGIT      = 99;
   localparam longint unsigned TIMEOUT_NS = 5_000_000;
   localparam logic [63:0] ALL_ONES = '1;
   localparam logic [7:0] SCALE_LETTERS [4] = '{"k", "m", "g", "t"};

   typedef logic [7:0] char_list_type[$];

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_payload_type          req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_payload_type          rsp_payload;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // parser model state
   phase_type                  scan_phase;
   logic [63:0]                scan_value;
   radix_type                  scan_radix;
   logic                       scan_negative;
   logic                       scan_overflow;
   logic                       scan_error;
   logic [WORD_BYTES_BITS-1:0] word_bytes_model;

   rsp_payload_type expected_counts[$];
   rsp_payload_type oldest_expected;
   int unsigned     mismatch_count = 0;
   int unsigned     items_sent = 0;
   bit              req_idle_on = 1'b1;
   bit              rsp_idle_on = 1'b1;
   bit              hold_request = 1'b0;

   size_string_to_bytes_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // ---------------- parser model ----------------

   function automatic int unsigned char_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return NOT_A_DIGIT;
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic int unsigned scan_base();
      case (scan_radix)
         RX_OCT:  return 8;
         RX_HEX:  return 16;
         default: return 10;
      endcase
   endfunction

   function automatic void clear_scan();
      scan_phase    = PH_WS;
      scan_value    = '0;
      scan_radix    = RX_DEC;
      scan_negative = 1'b0;
      scan_overflow = 1'b0;
      scan_error    = 1'b0;
   endfunction

   function automatic void accumulate_digit(input int unsigned d);
      logic [63:0] base;
      base = 64'(scan_base());
      if (scan_overflow) return;
      if (scan_value > (ALL_ONES - 64'(d)) / base) scan_overflow = 1'b1;
      else scan_value = scan_value * base + 64'(d);
   endfunction

   // saturate on overflow, else apply the sign
   function automatic void settle_number();
      if (scan_overflow) scan_value = ALL_ONES;
      else if (scan_negative) scan_value = -scan_value;
      scan_overflow = 1'b0;
      scan_negative = 1'b0;
   endfunction

   function automatic void apply_scale(input logic [63:0] factor);
      scan_value = scan_value * factor;
   endfunction

   function automatic void take_first_unit(input logic [7:0] c);
      logic [7:0] l;
      l = fold_case(c);
      scan_phase = PH_UNIT2;
      case (l)
         "k": apply_scale(64'd1 << 10);
         "m": apply_scale(64'd1 << 20);
         "g": apply_scale(64'd1 << 30);
         "t": apply_scale(64'd1 << 40);
         default: begin
            scan_phase = PH_DONE;
            if (l != "b" && c != CH_NUL) scan_error = 1'b1;
         end
      endcase
   endfunction

   function automatic void begin_digits(input logic [7:0] c);
      scan_value = '0;
      if (c == "0") begin
         scan_radix = RX_OCT;
         scan_phase = PH_ZERO;
      end else if (c >= "1" && c <= "9") begin
         scan_radix = RX_DEC;
         scan_value = 64'(c - "0");
         scan_phase = PH_DIG;
      end else begin
         scan_negative = 1'b0;
         scan_phase = PH_DONE;
      end
   endfunction

   function automatic void predict_char(input logic [7:0] c, input logic last_char);
      int unsigned     d;
      rsp_payload_type r;
      d = char_digit(c);
      case (scan_phase)
         PH_WS: begin
            if (!is_blank(c)) begin
               if (c == "+" || c == "-") begin
                  scan_negative = (c == "-");
                  scan_phase = PH_SIGN;
               end else begin
                  begin_digits(c);
               end
            end
         end
         PH_SIGN: begin_digits(c);
         PH_ZERO: begin
            if (c == "x" || c == "X") begin
               scan_phase = PH_XPRE;
            end else if (d < 8) begin
               accumulate_digit(d);
               scan_phase = PH_DIG;
            end else begin
               settle_number();
               take_first_unit(c);
            end
         end
         PH_XPRE: begin
            if (d < 16) begin
               scan_radix = RX_HEX;
               scan_value = 64'(d);
               scan_phase = PH_DIG;
            end else begin
               scan_error = 1'b1;
               scan_phase = PH_DONE;
            end
         end
         PH_DIG: begin
            if (d < scan_base()) begin
               accumulate_digit(d);
            end else begin
               settle_number();
               take_first_unit(c);
            end
         end
         PH_UNIT2: begin
            if (fold_case(c) == "w") apply_scale(64'(word_bytes_model));
            else if (fold_case(c) != "b" && c != CH_NUL) scan_error = 1'b1;
            scan_phase = PH_DONE;
         end
         default: ;
      endcase
      if (last_char) begin
         if (scan_phase == PH_ZERO || scan_phase == PH_DIG) settle_number();
         else if (scan_phase == PH_XPRE) scan_error = 1'b1;
         else if (scan_phase == PH_WS || scan_phase == PH_SIGN) scan_value = '0;
         r.byte_count  = scan_error ? '0 : scan_value;
         r.parse_error = scan_error;
         expected_counts.push_back(r);
         clear_scan();
      end
   endfunction

   // ---------------- string generation ----------------

   function automatic logic [7:0] random_case(input logic [7:0] c);
      return ($urandom_range(0, 1) == 1 && c >= "a" && c <= "z") ? c - 8'h20 : c;
   endfunction

   function automatic logic [7:0] digit_char(input int unsigned v);
      return random_case(v < 10 ? 8'("0" + v) : 8'("a" + v - 10));
   endfunction

   function automatic char_list_type make_size_string();
      char_list_type s;
      int            shape;
      int            n;
      int            blank;
      int            unit_pick;
      bit            scaled;
      scaled = 1'b0;
      shape = $urandom_range(0, 19);
      if (shape < 2) begin
         repeat ($urandom_range(1, 4)) s.push_back(8'($urandom_range(0, 255)));
         return s;
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            blank = $urandom_range(8, 13);
            s.push_back(blank == 8 ? " " : 8'(blank));
         end
      end
      case ($urandom_range(0, 5))
         0: s.push_back("+");
         1: s.push_back("-");
         default: ;
      endcase
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 6);
      if (shape == 2) n = 0;
      case ($urandom_range(0, 3))
         0, 1: begin
            if (n > 0) s.push_back(digit_char($urandom_range(1, 9)));
            for (int i = 1; i < n; i++) s.push_back(digit_char($urandom_range(0, 9)));
         end
         2: begin
            if (n > 0) s.push_back("0");
            for (int i = 1; i < n; i++) s.push_back(digit_char($urandom_range(0, 7)));
         end
         default: begin
            s.push_back("0");
            s.push_back(random_case("x"));
            if (shape != 3) begin
               for (int i = 0; i < n; i++) s.push_back(digit_char($urandom_range(0, 15)));
            end
         end
      endcase
      unit_pick = $urandom_range(0, 9);
      case (unit_pick)
         0, 1: ;
         6: s.push_back(random_case("b"));
         7: s.push_back(8'($urandom_range(0, 255)));
         default: begin
            s.push_back(random_case(SCALE_LETTERS[$urandom_range(0, 3)]));
            scaled = 1'b1;
         end
      endcase
      if (scaled) begin
         case ($urandom_range(0, 4))
            0: s.push_back(random_case("b"));
            1, 2: s.push_back(random_case("w"));
            3: s.push_back(8'($urandom_range(0, 255)));
            default: ;
         endcase
      end
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 2)) s.push_back(8'($urandom_range(0, 255)));
      end
      if (s.size() == 0) s.push_back(digit_char($urandom_range(0, 9)));
      return s;
   endfunction

   // ---------------- drivers ----------------

   task automatic send_char(input logic [7:0] c, input logic last_char);
      req_payload_type p;
      p.character = c;
      p.last_char = last_char;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_char(c, last_char);
      items_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_char(text[i], i == text.len() - 1);
   endtask

   task automatic send_string(input char_list_type s);
      foreach (s[i]) send_char(s[i], i == s.size() - 1);
   endtask

   // drop valid, let all results drain, then give the pipeline time to empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_word_bytes(input logic [WORD_BYTES_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] data;
      data = $urandom;
      if ($urandom_range(0, 1) == 1) data = '0;
      data[WORD_BYTES_BITS-1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_WORD_BYTES;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      word_bytes_model = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== CSR_DATA_BITS'(value)) begin
         mismatch_count++;
         $display("%0t: word_bytes read back, expected %h actual %h",
                  $time, CSR_DATA_BITS'(value), prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------- result side ----------------

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_counts.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with none pending, expected none, actual %h/%b",
                     $time, rsp_payload.byte_count, rsp_payload.parse_error);
         end else begin
            oldest_expected = expected_counts.pop_front();
            if (rsp_payload.byte_count !== oldest_expected.byte_count) begin
               mismatch_count++;
               $display("%0t: byte_count expected %h actual %h",
                        $time, oldest_expected.byte_count, rsp_payload.byte_count);
            end
            if (rsp_payload.parse_error !== oldest_expected.parse_error) begin
               mismatch_count++;
               $display("%0t: parse_error expected %b actual %b",
                        $time, oldest_expected.parse_error, rsp_payload.parse_error);
            end
         end
      end
   end

   // ---------------- tests ----------------

   task automatic test_directed_cases();
      send_text("\t-12Mb");
      send_text("0x");
      send_text("017Gw");
      send_char("3", 1'b0);
      send_char(CH_NUL, 1'b0);
      send_char("z", 1'b1);
      send_text("+");
      send_text("5q");
      send_char(8'hFF, 1'b1);
      send_text("8kbX");
   endtask

   task automatic test_word_size_sweep();
      logic [WORD_BYTES_BITS-1:0] sizes [5];
      sizes = '{5'd1, 5'd16, 5'd0, 5'd31, WORD_BYTES_RESET};
      foreach (sizes[i]) begin
         wait_idle();
         write_word_bytes(sizes[i]);
         send_text("5kw");
         send_text("-3TW");
         send_text("0x7fgb");
         repeat (6) send_string(make_size_string());
      end
   endtask

   // receiver holds off while single-character strings keep coming
   task automatic test_output_hold();
      wait_idle();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_request = 1'b1;
      repeat (16) send_char(8'("0" + $urandom_range(0, 9)), 1'b1);
      send_text("42m");
      wait_idle();
   endtask

   task automatic test_random_strings();
      int unsigned strings_done;
      strings_done = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (strings_done % 40 == 39) begin
            wait_idle();
            write_word_bytes(WORD_BYTES_BITS'($urandom_range(0, 31)));
         end
         if (strings_done % 10 == 0) begin
            req_idle_on = $urandom_range(0, 3) != 0;
            rsp_idle_on = $urandom_range(0, 3) != 0;
         end
         send_string(make_size_string());
         strings_done++;
      end
   endtask

   task automatic test_full_rate();
      wait_idle();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (25) send_string(make_size_string());
      wait_idle();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      clear_scan();
      word_bytes_model = WORD_BYTES_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_word_size_sweep();
      test_output_hold();
      test_random_strings();
      test_full_rate();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL");
      $finish;
   end

endmodule
